// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cie_pkg.sv =====
package cie_pkg;

   // Field widths.
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned SEV_W      = 2;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned CODE_W     = 2 * WORD_W;
   localparam int unsigned LETTER_W   = 5;
   localparam int unsigned SEV_SHIFT  = 30;
   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned MARK_W     = 5;

   // Digit count saturates here.
   localparam logic [COUNT_W-1:0] MAX_COUNT = 4'd10;

   // One input item as it sits in the input register.
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_char;
      logic [SEV_W-1:0]  severity;
   } item_type;

   // Control view of the input register for the accumulator.
   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

   // Parse state that the accumulator reports upward.
   typedef struct packed {
      logic in_digits;
      logic count_zero;
   } status_type;

   // Marker bit position selected by the saturated digit count.
   function automatic logic [MARK_W-1:0] marker_bit(input logic [COUNT_W-1:0] count);
      logic [MARK_W-1:0] pos;
      case (count)
         4'd0:    pos = 5'd0;
         4'd1:    pos = 5'd4;
         4'd2:    pos = 5'd7;
         4'd3:    pos = 5'd10;
         4'd4:    pos = 5'd14;
         4'd5:    pos = 5'd17;
         4'd6:    pos = 5'd20;
         4'd7:    pos = 5'd24;
         4'd8:    pos = 5'd27;
         4'd9:    pos = 5'd30;
         default: pos = 5'd31;
      endcase
      return pos;
   endfunction

endpackage

// ===== hw/rtl/cie_in_stage.sv =====
module cie_in_stage
   import cie_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  item_type      req_item,
   input  logic          advance,
   output item_type      item,
   output stage_ctl_type ctl
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;

   // The register takes a new transfer when empty or when its item moves on.
   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item      = item_ff;
   assign ctl.valid = valid_ff;
   assign ctl.last  = item_ff.last_char;

endmodule

// ===== hw/rtl/cie_accum.sv =====
module cie_accum
   import cie_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  item_type            item,
   input  stage_ctl_type       ctl,
   output logic                advance,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [CODE_W-1:0]   rsp_code,
   output logic                rsp_bad_char,
   output status_type          status
);

   logic [WORD_W-1:0]  letter_word_ff, letter_word_in;
   logic [WORD_W-1:0]  digit_value_ff, digit_value_in;
   logic [COUNT_W-1:0] digit_count_ff, digit_count_in;
   logic               in_digits_ff, in_digits_in;
   logic               error_seen_ff, error_seen_in;
   logic               out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]  code_ff;
   logic               bad_ff;

   logic               is_upper, is_lower, is_digit, take_letter;
   logic [WORD_W-1:0]  word_nx, value_nx;
   logic [COUNT_W-1:0] count_nx;
   logic               digits_nx, error_nx;
   logic [WORD_W-1:0]  code_hi, code_lo;
   logic [CODE_W-1:0]  code_nx;
   logic               emit;

   // An item moves on unless it must emit while the result register is held.
   assign advance = ctl.valid && (!ctl.last || !out_valid_ff || rsp_tready);
   assign emit    = advance && ctl.last;

   // Character classes.
   always_comb begin
      is_upper    = item.character inside {[8'h41:8'h5A]};
      is_lower    = item.character inside {[8'h61:8'h7A]};
      is_digit    = item.character inside {[8'h30:8'h39]};
      take_letter = !in_digits_ff && (is_upper || is_lower);
   end

   // Next parse state. The low five bits of an ASCII letter are its
   // position in the alphabet for either case.
   always_comb begin
      word_nx   = letter_word_ff;
      value_nx  = digit_value_ff;
      count_nx  = digit_count_ff;
      digits_nx = in_digits_ff;
      error_nx  = error_seen_ff;
      if (take_letter) begin
         word_nx = {letter_word_ff[WORD_W-LETTER_W-1:0], item.character[LETTER_W-1:0]};
      end else begin
         digits_nx = 1'b1;
         if (is_digit) begin
            value_nx = (digit_value_ff << 3) + (digit_value_ff << 1)
                     + {{(WORD_W-4){1'b0}}, item.character[3:0]};
         end else begin
            error_nx = 1'b1;
         end
         if (digit_count_ff < MAX_COUNT) begin
            count_nx = digit_count_ff + 4'd1;
         end
      end
   end

   // Result word; an error forces the code to zero.
   always_comb begin
      code_hi = word_nx | ({{(WORD_W-SEV_W){1'b0}}, item.severity} << SEV_SHIFT);
      code_lo = value_nx | ({{(WORD_W-1){1'b0}}, 1'b1} << marker_bit(count_nx));
      code_nx = error_nx ? '0 : {code_hi, code_lo};
   end

   // State update; the last character returns the parser to its reset values.
   always_comb begin
      letter_word_in = letter_word_ff;
      digit_value_in = digit_value_ff;
      digit_count_in = digit_count_ff;
      in_digits_in   = in_digits_ff;
      error_seen_in  = error_seen_ff;
      if (advance) begin
         if (ctl.last) begin
            letter_word_in = '0;
            digit_value_in = '0;
            digit_count_in = '0;
            in_digits_in   = 1'b0;
            error_seen_in  = 1'b0;
         end else begin
            letter_word_in = word_nx;
            digit_value_in = value_nx;
            digit_count_in = count_nx;
            in_digits_in   = digits_nx;
            error_seen_in  = error_nx;
         end
      end
   end

   // Result register valid flag.
   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_word_ff <= '0;
         digit_value_ff <= '0;
         digit_count_ff <= '0;
         in_digits_ff   <= 1'b0;
         error_seen_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         letter_word_ff <= letter_word_in;
         digit_value_ff <= digit_value_in;
         digit_count_ff <= digit_count_in;
         in_digits_ff   <= in_digits_in;
         error_seen_ff  <= error_seen_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Result payload loads only when a code is emitted.
   always_ff @(posedge clock) begin
      if (emit) begin
         code_ff <= code_nx;
         bad_ff  <= error_nx;
      end
   end

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_code          = code_ff;
   assign rsp_bad_char      = bad_ff;
   assign status.in_digits  = in_digits_ff;
   assign status.count_zero = (digit_count_ff == '0);

endmodule

// ===== hw/rtl/code_id_encoder.sv =====
// A character transfer is loaded into the input register and parsed from there; a last
// character loads its code into the result register, which offers it on rsp.
// Throughput: one character per cycle; the result register stalls the input only
// when a last character waits on a code that rsp has not taken.
// Reset (synchronous, active high) empties both registers and clears the parser.
`include "assert_macros.svh"

module code_id_encoder
   import cie_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] character
   input  logic              req_tlast,
   input  logic [SEV_W-1:0]  req_tuser,   // [1:0] severity
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CODE_W-1:0] rsp_tdata,   // [63:0] code
   output logic              rsp_tuser    // [0] bad_char
);

   item_type      req_item;
   item_type      item;
   stage_ctl_type ctl;
   status_type    status;
   logic          advance;

   assign req_item.character = req_tdata;
   assign req_item.last_char = req_tlast;
   assign req_item.severity  = req_tuser;

   cie_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item       (item),
      .ctl        (ctl)
   );

   cie_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .ctl          (ctl),
      .advance      (advance),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_code     (rsp_tdata),
      .rsp_bad_char (rsp_tuser),
      .status       (status)
   );

   // A flagged identifier always carries a zero code.
   `ASSERT_IMPL(a_bad_zero, clock, reset, rsp_tvalid && rsp_tuser,
                rsp_tdata == '0, "bad code not zero")

   // A good code always has its marker bit set in the low word.
   `ASSERT_IMPL(a_marker_set, clock, reset, rsp_tvalid && !rsp_tuser,
                rsp_tdata[WORD_W-1:0] != '0, "marker missing")

   // The input register holds only while a finished code waits downstream.
   `ASSERT_IMPL(a_stall_cause, clock, reset, ctl.valid && !advance,
                ctl.last && rsp_tvalid && !rsp_tready, "spurious stall")

   // Finishing an identifier leaves the parser in its letter phase.
   `ASSERT_NEXT(a_parser_clear, clock, reset, advance && ctl.last,
                !status.in_digits && status.count_zero, "parser not cleared")

endmodule
